// ===== sv/mst_pkg.sv =====
`timescale 1ns / 1ps
// mst_pkg: shared types, event codes and sizes of the multitouch slot tracker
// no dependencies; imported by mst_front, mst_back and the top level
package mst_pkg;

  localparam int SLOT_COUNT = 10;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int SLOT_IDX_W = 4;

  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = 2;
  localparam int OUTQ_DEPTH = 2;
  localparam int OUTQ_AW    = 1;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_EN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MULTI_EN  = 1'b1;

  localparam logic OP_ABS = 1'b0;
  localparam logic OP_SYN = 1'b1;

  localparam logic [15:0] CODE_ABS_X        = 16'h0000;
  localparam logic [15:0] CODE_ABS_Y        = 16'h0001;
  localparam logic [15:0] CODE_ABS_PRESSURE = 16'h0018;
  localparam logic [15:0] CODE_MT_SLOT      = 16'h002f;
  localparam logic [15:0] CODE_MT_POS_X     = 16'h0035;
  localparam logic [15:0] CODE_MT_POS_Y     = 16'h0036;
  localparam logic [15:0] CODE_MT_TRACK     = 16'h0039;
  localparam logic [15:0] CODE_SYN_REPORT   = 16'h0000;

  localparam logic [31:0] TRACK_END = 32'hffff_ffff;

  localparam logic KIND_PRIMARY = 1'b0;
  localparam logic KIND_SLOT    = 1'b1;

  typedef struct packed {
    logic               op;
    logic        [15:0] code;
    logic signed [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic                  report_kind;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic signed [31:0]    pos_x;
    logic signed [31:0]    pos_y;
    logic signed [31:0]    touch_pressure;
    logic signed [31:0]    track_id;
    logic                  last;
  } out_word_t;

  typedef enum logic [2:0] {
    CMD_SET_X,
    CMD_SET_Y,
    CMD_SET_PRESS,
    CMD_SLOT,
    CMD_TRACK,
    CMD_MT_X,
    CMD_MT_Y,
    CMD_REPORT
  } cmd_op_t;

  // flag: slot in range for CMD_SLOT, contact end for CMD_TRACK
  typedef struct packed {
    cmd_op_t     op;
    logic        flag;
    logic [31:0] value;
  } cmd_t;

endpackage

// ===== sv/mst_front.sv =====
`timescale 1ns / 1ps
// mst_front: decodes input events into commands and queues them for the back end
// depends on mst_pkg
module mst_front import mst_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  in_word_t in_word,
  output logic     cmd_valid,
  output cmd_t     cmd_out,
  input  logic     cmd_pop
);

  cmd_t               cmdq_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMDQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMDQ_AW:0]   cnt_r, cnt_nxt;
  logic               accept;
  logic               keep;
  logic               q_push;
  logic               q_pop;
  cmd_t               cmd_new;

  assign in_full   = (cnt_r == (CMDQ_AW + 1)'(CMDQ_DEPTH));
  assign accept    = in_push && !in_full;
  assign cmd_valid = (cnt_r != '0);
  assign cmd_out   = cmdq_r[rd_ptr_r];

  // decode; events with no effect are dropped here
  always_comb begin
    keep          = 1'b1;
    cmd_new.op    = CMD_REPORT;
    cmd_new.flag  = 1'b0;
    cmd_new.value = in_word.value;
    if (in_word.op == OP_SYN) begin
      keep = (in_word.code == CODE_SYN_REPORT);
    end else begin
      case (in_word.code)
        CODE_ABS_X:        cmd_new.op = CMD_SET_X;
        CODE_ABS_Y:        cmd_new.op = CMD_SET_Y;
        CODE_ABS_PRESSURE: cmd_new.op = CMD_SET_PRESS;
        CODE_MT_SLOT: begin
          cmd_new.op   = CMD_SLOT;
          cmd_new.flag = ($unsigned(in_word.value) < 32'(SLOT_COUNT));
        end
        CODE_MT_TRACK: begin
          cmd_new.op   = CMD_TRACK;
          cmd_new.flag = ($unsigned(in_word.value) == TRACK_END);
        end
        CODE_MT_POS_X:     cmd_new.op = CMD_MT_X;
        CODE_MT_POS_Y:     cmd_new.op = CMD_MT_Y;
        default:           keep = 1'b0;
      endcase
    end
  end

  assign q_push = accept && keep;
  assign q_pop  = cmd_pop && cmd_valid;

  always_comb begin
    wr_ptr_nxt = q_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (CMDQ_AW + 1)'(q_push) - (CMDQ_AW + 1)'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (q_push) begin
      cmdq_r[wr_ptr_r] <= cmd_new;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (CMDQ_AW + 1)'(CMDQ_DEPTH))
    else $error("command queue count overflow");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cmd_valid)
    else $error("command popped from empty queue");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("command queue pointers out of step");

endmodule

// ===== sv/mst_back.sv =====
`timescale 1ns / 1ps
// mst_back: slot and primary point state, report scan and result queue
// depends on mst_pkg; fed by mst_front
module mst_back import mst_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cmd_valid,
  input  cmd_t                  cmd_in,
  output logic                  cmd_pop,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_empty,
  input  logic                  out_pop,
  output out_word_t             out_word
);

  typedef enum logic [1:0] {ST_RUN, ST_PRIM, ST_SCAN} state_t;

  state_t              state_r, state_nxt;
  logic [31:0]         slot_x_r [SLOT_COUNT];
  logic [31:0]         slot_x_nxt [SLOT_COUNT];
  logic [31:0]         slot_y_r [SLOT_COUNT];
  logic [31:0]         slot_y_nxt [SLOT_COUNT];
  logic [31:0]         slot_trk_r [SLOT_COUNT];
  logic [31:0]         slot_trk_nxt [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] active_r, active_nxt;
  logic [31:0]         prim_x_r, prim_x_nxt;
  logic [31:0]         prim_y_r, prim_y_nxt;
  logic [31:0]         prim_p_r, prim_p_nxt;
  logic                prim_act_r, prim_act_nxt;
  logic [SLOT_W-1:0]   sel_r, sel_nxt;
  logic                sel_ok_r, sel_ok_nxt;
  logic [SLOT_W-1:0]   scan_r, scan_nxt;
  logic                multi_go_r, multi_go_nxt;
  logic                single_en_r, multi_en_r;

  out_word_t           oq_r [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0]  oq_wr_r, oq_rd_r;
  logic [OUTQ_AW:0]    oq_cnt_r;
  logic                oq_full;
  logic                oq_push;
  logic                oq_pop;
  out_word_t           oq_din;

  logic [SLOT_W-1:0]     rd_idx;
  logic [31:0]           cur_x, cur_y, cur_trk;
  logic [SLOT_COUNT-1:0] sel_mask;
  logic [SLOT_COUNT-1:0] later_mask;
  logic                  prim_go, multi_go;

  assign oq_full   = (oq_cnt_r == (OUTQ_AW + 1)'(OUTQ_DEPTH));
  assign out_empty = (oq_cnt_r == '0);
  assign out_word  = oq_r[oq_rd_r];
  assign oq_pop    = out_pop && !out_empty;

  // single slot read port, shared by event handling and the report scan
  assign rd_idx   = (state_r == ST_SCAN) ? scan_r : sel_r;
  assign cur_x    = slot_x_r[rd_idx];
  assign cur_y    = slot_y_r[rd_idx];
  assign cur_trk  = slot_trk_r[rd_idx];
  assign sel_mask = SLOT_COUNT'(1) << sel_r;

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      later_mask[i] = (i > int'(scan_r));
    end
  end

  assign prim_go  = prim_act_r && single_en_r;
  assign multi_go = multi_en_r && (|active_r);

  always_comb begin
    state_nxt    = state_r;
    slot_x_nxt   = slot_x_r;
    slot_y_nxt   = slot_y_r;
    slot_trk_nxt = slot_trk_r;
    active_nxt   = active_r;
    prim_x_nxt   = prim_x_r;
    prim_y_nxt   = prim_y_r;
    prim_p_nxt   = prim_p_r;
    prim_act_nxt = prim_act_r;
    sel_nxt      = sel_r;
    sel_ok_nxt   = sel_ok_r;
    scan_nxt     = scan_r;
    multi_go_nxt = multi_go_r;
    cmd_pop      = 1'b0;
    oq_push      = 1'b0;
    oq_din       = '0;
    case (state_r)
      ST_RUN: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          case (cmd_in.op)
            CMD_SET_X:     prim_x_nxt = cmd_in.value;
            CMD_SET_Y:     prim_y_nxt = cmd_in.value;
            CMD_SET_PRESS: prim_p_nxt = cmd_in.value;
            CMD_SLOT: begin
              sel_nxt    = cmd_in.value[SLOT_W-1:0];
              sel_ok_nxt = cmd_in.flag;
            end
            CMD_TRACK: begin
              if (sel_ok_r) begin
                slot_trk_nxt[sel_r] = cmd_in.value;
                active_nxt[sel_r]   = !cmd_in.flag;
                if (!cmd_in.flag) begin
                  prim_x_nxt   = cur_x;
                  prim_y_nxt   = cur_y;
                  prim_p_nxt   = '0;
                  prim_act_nxt = 1'b1;
                end else if (!(|(active_r & ~sel_mask))) begin
                  prim_act_nxt = 1'b0;
                end
              end
            end
            CMD_MT_X: begin
              if (sel_ok_r) begin
                slot_x_nxt[sel_r] = cmd_in.value;
                if (!prim_act_r) begin
                  prim_x_nxt   = cmd_in.value;
                  prim_act_nxt = 1'b1;
                end
              end
            end
            CMD_MT_Y: begin
              if (sel_ok_r) begin
                slot_y_nxt[sel_r] = cmd_in.value;
                if (!prim_act_r) begin
                  prim_y_nxt   = cmd_in.value;
                  prim_act_nxt = 1'b1;
                end
              end
            end
            CMD_REPORT: begin
              multi_go_nxt = multi_go;
              scan_nxt     = '0;
              if (prim_go) begin
                state_nxt = ST_PRIM;
              end else if (multi_go) begin
                state_nxt = ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_PRIM: begin
        if (!oq_full) begin
          oq_push               = 1'b1;
          oq_din.report_kind    = KIND_PRIMARY;
          oq_din.pos_x          = prim_x_r;
          oq_din.pos_y          = prim_y_r;
          oq_din.touch_pressure = prim_p_r;
          oq_din.last           = !multi_go_r;
          state_nxt             = multi_go_r ? ST_SCAN : ST_RUN;
        end
      end
      ST_SCAN: begin
        if (!active_r[scan_r] || !oq_full) begin
          if (active_r[scan_r]) begin
            oq_push            = 1'b1;
            oq_din.report_kind = KIND_SLOT;
            oq_din.slot_index  = SLOT_IDX_W'(scan_r);
            oq_din.pos_x       = cur_x;
            oq_din.pos_y       = cur_y;
            oq_din.track_id    = cur_trk;
            oq_din.last        = !(|(active_r & later_mask));
          end
          if (scan_r == SLOT_W'(SLOT_COUNT - 1)) begin
            state_nxt = ST_RUN;
          end else begin
            scan_nxt = scan_r + 1'b1;
          end
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      active_r    <= '0;
      prim_x_r    <= '0;
      prim_y_r    <= '0;
      prim_p_r    <= '0;
      prim_act_r  <= 1'b0;
      sel_r       <= '0;
      sel_ok_r    <= 1'b1;
      scan_r      <= '0;
      multi_go_r  <= 1'b0;
      single_en_r <= 1'b0;
      multi_en_r  <= 1'b0;
      oq_wr_r     <= '0;
      oq_rd_r     <= '0;
      oq_cnt_r    <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_x_r[i]   <= '0;
        slot_y_r[i]   <= '0;
        slot_trk_r[i] <= '0;
      end
    end else begin
      state_r    <= state_nxt;
      active_r   <= active_nxt;
      prim_x_r   <= prim_x_nxt;
      prim_y_r   <= prim_y_nxt;
      prim_p_r   <= prim_p_nxt;
      prim_act_r <= prim_act_nxt;
      sel_r      <= sel_nxt;
      sel_ok_r   <= sel_ok_nxt;
      scan_r     <= scan_nxt;
      multi_go_r <= multi_go_nxt;
      slot_x_r   <= slot_x_nxt;
      slot_y_r   <= slot_y_nxt;
      slot_trk_r <= slot_trk_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_SINGLE_EN: single_en_r <= cfg_data[0];
          CFG_MULTI_EN:  multi_en_r  <= cfg_data[0];
          default: ;
        endcase
      end
      if (oq_push) begin
        oq_wr_r <= oq_wr_r + 1'b1;
      end
      if (oq_pop) begin
        oq_rd_r <= oq_rd_r + 1'b1;
      end
      oq_cnt_r <= oq_cnt_r + (OUTQ_AW + 1)'(oq_push) - (OUTQ_AW + 1)'(oq_pop);
    end
    if (oq_push) begin
      oq_r[oq_wr_r] <= oq_din;
    end
  end

  a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    oq_cnt_r <= (OUTQ_AW + 1)'(OUTQ_DEPTH))
    else $error("result queue count overflow");

  // the scan may still walk idle slots after the last word, but emits nothing
  a_last_ends_report: assert property (@(posedge clk) disable iff (!rst_n)
    (oq_push && oq_din.last) |=> !oq_push)
    else $error("report continued after its last word");

  a_slot_word_active: assert property (@(posedge clk) disable iff (!rst_n)
    (oq_push && oq_din.report_kind == KIND_SLOT) |-> active_r[scan_r])
    else $error("slot word emitted for an inactive slot");

  a_no_cmd_in_report: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_RUN) |-> !cmd_pop)
    else $error("command taken during a report");

endmodule

// ===== sv/multitouch_slot_tracker_unit.sv =====
`timescale 1ns / 1ps
// multitouch_slot_tracker_unit: top level of the multitouch slot tracker
// depends on mst_pkg, mst_front and mst_back
//
// Tracks up to SLOT_COUNT (10) touch slots and one primary point from a
// stream of input-layer style events (absolute axis or sync), following the
// protocol B slot rules. Input words are taken whenever in_full is low and
// go through a four-entry command queue, so the source is only held off when
// the back end falls behind. Words that change nothing (unknown codes,
// non-report sync codes) are dropped at the input. The back end handles one
// command at a time through a single slot read port: an absolute event is
// applied when it is popped; a sync report is decided first, then emits the
// primary point word when one is due, then scans the slots in ascending
// order (the scan is skipped entirely when no slot is active or slot reports
// are off); no new command is taken until the report is done, and a full
// result queue stalls the primary word and each active slot word. Result
// words leave through a two-entry queue (out_empty/out_pop); the final word
// of each report has last set. Configuration writes take effect on the next
// report decision; they are meant to be made while the block is idle.
module multitouch_slot_tracker_unit import mst_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // event input
  input  logic                  in_push,
  output logic                  in_full,
  input  in_word_t              in_word,
  // report output
  output logic                  out_empty,
  input  logic                  out_pop,
  output out_word_t             out_word,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // decoded command between the front and back halves
  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  // front: decode and queue
  mst_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_word   (in_word),
    .cmd_valid (cmd_valid),
    .cmd_out   (cmd),
    .cmd_pop   (cmd_pop)
  );

  // back: slot state, report scan, result queue
  mst_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_in    (cmd),
    .cmd_pop   (cmd_pop),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word)
  );

endmodule

// ===== bench/multitouch_slot_tracker_unit_tb.sv =====
`timescale 1ns / 1ps
// multitouch_slot_tracker_unit_tb: self-checking bench for the slot tracker top level
// depends on mst_pkg and multitouch_slot_tracker_unit; touch state is predicted here
module multitouch_slot_tracker_unit_tb;
  import mst_pkg::*;

  localparam int      IDLE_PCT        = 13;         // chance of an idle cycle per side
  localparam int      HOLD_CYCLES     = 200;        // long result-side hold-off
  localparam int      DRAIN_CYCLES    = 80;         // room for the 4 queued commands to finish
  localparam int      IDLE_WAIT_LIMIT = 20000;      // bound on waiting for the last report
  localparam longint  TIMEOUT_NS      = 64'd6_000_000;

  // shadow of the tracker: slots, primary point, selection and report enables
  class touch_scoreboard;
    logic [31:0] slot_x [SLOT_COUNT];
    logic [31:0] slot_y [SLOT_COUNT];
    logic [31:0] slot_track [SLOT_COUNT];
    bit          slot_live [SLOT_COUNT];
    logic [31:0] prim_x, prim_y, prim_press;
    bit          prim_live;
    logic [3:0]  sel_slot;
    bit          sel_ok;
    bit          single_en, multi_en;
    out_word_t   report_q[$];
    int          errors;
    int          words_checked;

    function new();
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_x[i] = '0;
        slot_y[i] = '0;
        slot_track[i] = '0;
        slot_live[i] = 1'b0;
      end
      prim_x = '0;
      prim_y = '0;
      prim_press = '0;
      prim_live = 1'b0;
      sel_slot = '0;
      sel_ok = 1'b1;
      single_en = 1'b0;
      multi_en = 1'b0;
      errors = 0;
      words_checked = 0;
    endfunction

    function void set_config(bit single, bit multi);
      single_en = single;
      multi_en = multi;
    endfunction

    function int reports_due();
      return report_q.size();
    endfunction

    // apply one accepted event; returns 1 when the event is one the block acts on
    function bit note_event(in_word_t w);
      logic [31:0] v;
      logic [3:0]  s;
      bit          ok;
      bit          any;
      int          first;
      out_word_t   r;
      v = w.value;
      s = sel_slot;
      ok = sel_ok && (s < SLOT_COUNT);
      if (w.op == OP_ABS) begin
        case (w.code)
          CODE_ABS_X:        prim_x = v;
          CODE_ABS_Y:        prim_y = v;
          CODE_ABS_PRESSURE: prim_press = v;
          CODE_MT_SLOT: begin
            sel_slot = v[3:0];
            sel_ok = (v < 32'(SLOT_COUNT));
          end
          CODE_MT_TRACK: begin
            if (ok) begin
              slot_track[s] = v;
              slot_live[s] = (v != TRACK_END);
              if (v != TRACK_END) begin
                prim_x = slot_x[s];
                prim_y = slot_y[s];
                prim_press = '0;
                prim_live = 1'b1;
              end else begin
                any = 1'b0;
                for (int i = 0; i < SLOT_COUNT; i++)
                  if (slot_live[i]) any = 1'b1;
                if (!any) prim_live = 1'b0;
              end
            end
          end
          CODE_MT_POS_X: begin
            if (ok) begin
              slot_x[s] = v;
              if (!prim_live) begin
                prim_x = v;
                prim_live = 1'b1;
              end
            end
          end
          CODE_MT_POS_Y: begin
            if (ok) begin
              slot_y[s] = v;
              if (!prim_live) begin
                prim_y = v;
                prim_live = 1'b1;
              end
            end
          end
          default: return 1'b0;
        endcase
        return 1'b1;
      end
      if (w.code != CODE_SYN_REPORT) return 1'b0;
      first = report_q.size();
      if (prim_live && single_en) begin
        r = '0;
        r.report_kind = KIND_PRIMARY;
        r.pos_x = prim_x;
        r.pos_y = prim_y;
        r.touch_pressure = prim_press;
        report_q.push_back(r);
      end
      if (multi_en) begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (slot_live[i]) begin
            r = '0;
            r.report_kind = KIND_SLOT;
            r.slot_index = SLOT_IDX_W'(i);
            r.pos_x = slot_x[i];
            r.pos_y = slot_y[i];
            r.track_id = slot_track[i];
            report_q.push_back(r);
          end
        end
      end
      if (report_q.size() > first) begin
        r = report_q.pop_back();
        r.last = 1'b1;
        report_q.push_back(r);
      end
      return 1'b1;
    endfunction

    function void match_field(string name, logic signed [31:0] want, logic signed [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_report(out_word_t got);
      out_word_t want;
      if (report_q.size() == 0) begin
        $error("report word with nothing predicted: %h", got);
        errors++;
        return;
      end
      want = report_q.pop_front();
      match_field("report_kind", 32'(want.report_kind), 32'(got.report_kind));
      match_field("slot_index", 32'(want.slot_index), 32'(got.slot_index));
      match_field("pos_x", want.pos_x, got.pos_x);
      match_field("pos_y", want.pos_y, got.pos_y);
      match_field("touch_pressure", want.touch_pressure, got.touch_pressure);
      match_field("track_id", want.track_id, got.track_id);
      match_field("last", 32'(want.last), 32'(got.last));
      words_checked++;
    endfunction

    function void flush_leftover();
      if (report_q.size() != 0) begin
        $error("%0d predicted report words never arrived", report_q.size());
        errors++;
        report_q.delete();
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_push = 1'b0;
  logic      in_full;
  in_word_t  in_word = '0;
  logic      out_empty;
  logic      out_pop = 1'b0;
  out_word_t out_word;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_SINGLE_EN;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  touch_scoreboard sb = new();
  bit calm = 1'b0;          // both sides run without idle cycles
  bit hold_req = 1'b0;      // ask the result side for one long hold-off
  int events_fed = 0;       // accepted words the block acts on
  int settings_run = 0;

  multitouch_slot_tracker_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_word   (in_word),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic in_word_t make_word(logic op, logic [15:0] code, logic [31:0] value);
    in_word_t w;
    w.op = op;
    w.code = code;
    w.value = value;
    return w;
  endfunction

  // mostly screen-sized coordinates, now and then any 32-bit value
  function automatic logic [31:0] pick_coord();
    if ($urandom_range(0, 99) < 85) return $urandom_range(0, 4095);
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_track_id();
    if ($urandom_range(0, 99) < 80) return $urandom_range(0, 65535);
    return $urandom;
  endfunction

  // offer one word; called and returns just after a falling edge
  task automatic push_word(in_word_t w);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_full);
    if (sb.note_event(w)) events_fed++;
    @(negedge clk);
  endtask

  // both enables in consecutive cycles, write enable held across them
  task automatic write_config(bit single, bit multi);
    cfg_we <= 1'b1;
    cfg_index <= CFG_SINGLE_EN;
    cfg_data <= single;
    @(negedge clk);
    cfg_index <= CFG_MULTI_EN;
    cfg_data <= multi;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_config(single, multi);
    settings_run++;
    @(negedge clk);
  endtask

  // wait for every predicted word, then let queued silent commands finish
  task automatic drain_idle();
    int waited;
    in_push <= 1'b0;
    for (waited = 0; sb.reports_due() != 0 && waited < IDLE_WAIT_LIMIT; waited++)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    sb.flush_leftover();
  endtask

  task automatic run_directed();
    // report straight after reset: nothing valid yet
    push_word(make_word(OP_SYN, CODE_SYN_REPORT, 32'h0));
    // direct primary axes at the extremes, primary stays invalid
    push_word(make_word(OP_ABS, CODE_ABS_X, 32'h7fff_ffff));
    push_word(make_word(OP_ABS, CODE_ABS_Y, 32'h8000_0000));
    push_word(make_word(OP_ABS, CODE_ABS_PRESSURE, 32'hffff_ffff));
    push_word(make_word(OP_SYN, CODE_SYN_REPORT, 32'hffff_ffff));
    // slot position with no primary makes the primary valid
    push_word(make_word(OP_ABS, CODE_MT_POS_X, 32'd100));
    push_word(make_word(OP_SYN, CODE_SYN_REPORT, 32'h0));
    // open contacts on the top and bottom slots
    push_word(make_word(OP_ABS, CODE_MT_SLOT, 32'(SLOT_COUNT - 1)));
    push_word(make_word(OP_ABS, CODE_MT_TRACK, 32'h7fff_ffff));
    push_word(make_word(OP_ABS, CODE_MT_POS_Y, 32'h8000_0000));
    push_word(make_word(OP_ABS, CODE_MT_SLOT, 32'h0));
    push_word(make_word(OP_ABS, CODE_MT_TRACK, 32'h0));
    push_word(make_word(OP_SYN, CODE_SYN_REPORT, 32'h0));
    // out of range slot selects, negative and just past the end; events ignored
    push_word(make_word(OP_ABS, CODE_MT_SLOT, 32'hffff_ffff));
    push_word(make_word(OP_ABS, CODE_MT_TRACK, 32'd5));
    push_word(make_word(OP_ABS, CODE_MT_POS_X, 32'd7));
    push_word(make_word(OP_ABS, CODE_MT_SLOT, 32'(SLOT_COUNT)));
    push_word(make_word(OP_ABS, CODE_MT_TRACK, TRACK_END));
    // unknown absolute code and non-report sync codes
    push_word(make_word(OP_ABS, 16'hffff, 32'h1234_5678));
    push_word(make_word(OP_SYN, 16'hffff, 32'h0));
    push_word(make_word(OP_SYN, 16'h0001, 32'h0));
    // end one contact while another stays, then the last one
    push_word(make_word(OP_ABS, CODE_MT_SLOT, 32'(SLOT_COUNT - 1)));
    push_word(make_word(OP_ABS, CODE_MT_TRACK, TRACK_END));
    push_word(make_word(OP_SYN, CODE_SYN_REPORT, 32'h0));
    push_word(make_word(OP_ABS, CODE_MT_SLOT, 32'h0));
    push_word(make_word(OP_ABS, CODE_MT_TRACK, TRACK_END));
    push_word(make_word(OP_SYN, CODE_SYN_REPORT, 32'h0));
  endtask

  // one random frame: mostly well-formed slot updates closed by a report,
  // otherwise noise, broken selections or stray primary axes
  task automatic send_frame();
    int          pick;
    int          act;
    int          n_upd;
    logic [31:0] v;
    logic [15:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 78) begin
      n_upd = $urandom_range(1, 4);
      repeat (n_upd) begin
        push_word(make_word(OP_ABS, CODE_MT_SLOT, $urandom_range(0, SLOT_COUNT - 1)));
        act = $urandom_range(0, 9);
        if (act < 3) begin
          push_word(make_word(OP_ABS, CODE_MT_TRACK, pick_track_id()));
        end else if (act < 5) begin
          push_word(make_word(OP_ABS, CODE_MT_TRACK, TRACK_END));
        end else if (act < 7) begin
          push_word(make_word(OP_ABS, CODE_MT_POS_X, pick_coord()));
          push_word(make_word(OP_ABS, CODE_MT_POS_Y, pick_coord()));
        end else if (act < 8) begin
          push_word(make_word(OP_ABS, CODE_MT_POS_X, pick_coord()));
        end else if (act < 9) begin
          push_word(make_word(OP_ABS, CODE_MT_POS_Y, pick_coord()));
        end else begin
          case ($urandom_range(0, 2))
            0:       c = CODE_ABS_X;
            1:       c = CODE_ABS_Y;
            default: c = CODE_ABS_PRESSURE;
          endcase
          push_word(make_word(OP_ABS, c, $urandom));
        end
      end
      push_word(make_word(OP_SYN, CODE_SYN_REPORT, $urandom));
    end else begin
      act = $urandom_range(0, 3);
      case (act)
        0: push_word(make_word(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                               $urandom));
        1: begin
          // bad selection, then slot events that must be dropped
          if ($urandom_range(0, 1)) v = $urandom_range(SLOT_COUNT, 15);
          else v = $urandom | 32'h8000_0000;
          push_word(make_word(OP_ABS, CODE_MT_SLOT, v));
          push_word(make_word(OP_ABS, CODE_MT_TRACK, pick_track_id()));
          push_word(make_word(OP_ABS, CODE_MT_POS_X, pick_coord()));
          push_word(make_word(OP_SYN, CODE_SYN_REPORT, 32'h0));
        end
        2: push_word(make_word(OP_ABS, CODE_ABS_PRESSURE, $urandom));
        default: push_word(make_word(OP_SYN, 16'($urandom_range(0, 3)), $urandom));
      endcase
    end
  endtask

  // sample accepted report words at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) sb.check_report(out_word);
  end

  // result side: random pops, one long hold-off on request
  initial begin : result_side
    int held;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_pop <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(negedge clk);
        hold_req = 1'b0;
      end
      out_pop <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  initial begin : stimulus
    bit single_set [5] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    bit multi_set  [5] = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
    int phase_len  [5] = '{60, 50, 50, 30, 45};
    int target;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // both report kinds on for the directed part
    write_config(1'b1, 1'b1);
    run_directed();
    for (int p = 0; p < 5; p++) begin
      drain_idle();
      write_config(single_set[p], multi_set[p]);
      calm = (p == 1);
      // first random phase: stall the result side so the block backs up
      if (p == 0) hold_req = 1'b1;
      target = events_fed + phase_len[p];
      while (events_fed < target) send_frame();
    end
    drain_idle();
    $display("covered %0d acted-on events under %0d enable settings", events_fed,
             settings_run);
    $display("checked %0d report words, %0d mismatches", sb.words_checked, sb.errors);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("FAILURE");
    $finish;
  end

endmodule
